// File: rtl/chd_pkg.sv
package chd_pkg;

    // request codes on the req_type field
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    // line-end characters of the chunked framing
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        req_type;
        logic        is_chunked;
        logic [63:0] content_length;
        logic [7:0]  data_byte;
    } chd_in_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       body_done;
        logic       framing_error;
    } chd_out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        is_chunked;
        logic [63:0] content_length;
        logic [7:0]  data_byte;
        logic        is_hex;
        logic [3:0]  hex_val;
        logic        is_cr;
        logic        is_lf;
    } chd_cls_t;

endpackage

// File: rtl/http_body_chunked_deframer.sv
// http body deframer: strips chunked or content-length framing off a body
//
// channels
//   item   : start words (req_type 0, framing fields) and body byte words
//            (req_type 1, data_byte); taken when item_valid and !item_stall
//   result : exactly one word for every item word, in order; taken when
//            result_valid and !result_stall
//
// timing
//   a taken word is classified and written into a two-entry queue; the
//   back end then pops it, updates the framing state and loads the result
//   register, so the queue entry and the result register lie between
//   acceptance and result_valid when the queue was empty and the output side is free
//   throughput is one word per cycle while result_stall is low, bounded by the
//   state update in the back end (64-bit count decrement or hex digit shift-in)
//
// reset clears the framing state to idle, clears the sticky error, and
// empties the queue and the result register
// a stalled result holds its value; the back end waits, the queue fills,
// and item_stall rises once both queue entries are taken
module http_body_chunked_deframer import chd_pkg::*; #(
    parameter int MAX_SIZE_CHARS = 20
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  chd_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output chd_out_t result
);

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     q_not_empty;
    chd_cls_t cls;
    chd_cls_t q_head;

    // front end: handshake and byte classification
    chd_front u_front (
        .item_valid (item_valid),
        .item       (item),
        .queue_full (queue_full),
        .item_stall (item_stall),
        .push       (push),
        .cls        (cls)
    );

    // decouples the input handshake from the state update
    chd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back end: framing state machine and result register
    chd_back #(
        .MAX_SIZE_CHARS (MAX_SIZE_CHARS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/chd_front.sv
module chd_front import chd_pkg::*; (
    input  logic     item_valid,
    input  chd_in_t  item,
    input  logic     queue_full,
    output logic     item_stall,
    output logic     push,
    output chd_cls_t cls
);

    logic [7:0] b;
    logic [7:0] dig_off;
    logic [7:0] low_off;
    logic [7:0] up_off;

    assign b       = item.data_byte;
    assign dig_off = b - 8'h30;
    assign low_off = b - 8'h57;
    assign up_off  = b - 8'h37;

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        cls                = '0;
        cls.is_start       = (item.req_type == REQ_START);
        cls.is_chunked     = item.is_chunked;
        cls.content_length = item.content_length;
        cls.data_byte      = b;
        cls.is_cr          = (b == CHAR_CR);
        cls.is_lf          = (b == CHAR_LF);
        priority if (b >= 8'h30 && b <= 8'h39)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = dig_off[3:0];
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = low_off[3:0];
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = up_off[3:0];
        end
        else
        begin
            cls.is_hex  = 1'b0;
            cls.hex_val = 4'h0;
        end
    end

endmodule

// File: rtl/chd_queue.sv
module chd_queue import chd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  chd_cls_t push_data,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output chd_cls_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    chd_cls_t       store [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/chd_back.sv
module chd_back import chd_pkg::*; #(
    parameter int MAX_SIZE_CHARS = 20
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_not_empty,
    input  chd_cls_t q_head,
    output logic     pop,
    output logic     result_valid,
    input  logic     result_stall,
    output chd_out_t result
);

    localparam int CNT_W = $clog2(MAX_SIZE_CHARS - 3);
    localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(MAX_SIZE_CHARS - 4);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_LENGTH   = 4'd1;
    localparam logic [3:0] PH_SIZE     = 4'd2;
    localparam logic [3:0] PH_SIZE_LF  = 4'd3;
    localparam logic [3:0] PH_DATA     = 4'd4;
    localparam logic [3:0] PH_DATA_CR  = 4'd5;
    localparam logic [3:0] PH_DATA_LF  = 4'd6;
    localparam logic [3:0] PH_FINAL_CR = 4'd7;
    localparam logic [3:0] PH_FINAL_LF = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;

    logic [3:0]       phase_reg, phase_next;
    logic [63:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic             out_valid_reg;
    chd_out_t         out_reg;
    chd_out_t         res;
    logic [63:0]      rem_dec;
    logic             bad;

    // next result may load when the output slot is empty or being taken
    assign pop          = q_not_empty && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign rem_dec      = rem_reg - 64'd1;

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        res        = '0;
        bad        = 1'b0;
        if (!err_reg)
        begin
            if (q_head.is_start)
            begin
                cnt_next = '0;
                rem_next = '0;
                priority if (q_head.is_chunked)
                begin
                    phase_next = PH_SIZE;
                end
                else if (q_head.content_length == 64'd0)
                begin
                    phase_next    = PH_DONE;
                    res.body_done = 1'b1;
                end
                else
                begin
                    rem_next   = q_head.content_length;
                    phase_next = PH_LENGTH;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LENGTH, PH_DATA:
                    begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = q_head.data_byte;
                        rem_next          = rem_dec;
                        if (rem_dec == 64'd0)
                        begin
                            if (phase_reg == PH_LENGTH)
                            begin
                                phase_next    = PH_DONE;
                                res.body_done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_DATA_CR;
                            end
                        end
                    end
                    PH_SIZE:
                    begin
                        priority if (q_head.is_hex)
                        begin
                            if (cnt_reg >= DIGIT_LIMIT)
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                rem_next = {rem_reg[59:0], q_head.hex_val};
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else if (q_head.is_cr && cnt_reg != '0)
                        begin
                            phase_next = PH_SIZE_LF;
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                    PH_SIZE_LF:
                    begin
                        if (!q_head.is_lf)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            phase_next = (rem_reg == 64'd0) ? PH_FINAL_CR : PH_DATA;
                        end
                    end
                    PH_DATA_CR:
                    begin
                        if (q_head.is_cr) phase_next = PH_DATA_LF;
                        else bad = 1'b1;
                    end
                    PH_DATA_LF:
                    begin
                        if (q_head.is_lf) phase_next = PH_SIZE;
                        else bad = 1'b1;
                    end
                    PH_FINAL_CR:
                    begin
                        if (q_head.is_cr) phase_next = PH_FINAL_LF;
                        else bad = 1'b1;
                    end
                    PH_FINAL_LF:
                    begin
                        if (q_head.is_lf)
                        begin
                            phase_next    = PH_DONE;
                            res.body_done = 1'b1;
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                    default:
                    begin
                        // no open body: idle or already complete
                        bad = 1'b1;
                    end
                endcase
            end
            if (bad)
            begin
                err_next = 1'b1;
                res      = '0;
            end
        end
        res.framing_error = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                rem_reg       <= rem_next;
                cnt_reg       <= cnt_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("framing error cleared without reset");

    a_no_payload_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.payload_valid |-> !out_reg.framing_error)
        else $error("payload byte passed with error set");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.payload_valid |-> out_reg.payload_byte == 8'h00)
        else $error("payload byte not zero while not valid");

    a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIGIT_LIMIT)
        else $error("size digit count beyond limit");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        pop && phase_next == PH_DONE && phase_reg != PH_DONE && !err_next
        |=> out_reg.body_done)
        else $error("body completed without done flag");

endmodule

// File: tb/tb_http_body_chunked_deframer.sv
`timescale 1ns / 100ps

module tb_http_body_chunked_deframer;
    import chd_pkg::*;

    // size field window of the block; a size line holds at most window - 4 digits
    localparam int SIZE_CHAR_WINDOW = 20;
    localparam int SIZE_DIGIT_LIMIT = SIZE_CHAR_WINDOW - 4;

    // random body words wanted before the closing error sequence
    localparam int BODY_WORD_TARGET = 1000;

    // long receiver hold-off: when it starts and how many cycles it lasts
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int HOLD_OFF_CYCLES = 250;

    // cycles allowed after the last expected word before the verdict
    localparam int DRAIN_CYCLES = 20;

    // deframer phases as the predictor tracks them
    typedef enum logic [3:0] {
        FR_IDLE,
        FR_COUNTED,
        FR_SIZE_HEX,
        FR_SIZE_LF,
        FR_CHUNK_DATA,
        FR_CHUNK_CR,
        FR_CHUNK_LF,
        FR_LAST_CR,
        FR_LAST_LF,
        FR_COMPLETE
    } frame_phase_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    chd_in_t  item         = '0;
    logic     result_stall = 1'b0;
    logic     item_stall;
    logic     result_valid;
    chd_out_t result;

    // words still to be offered, and deframed words still to come back
    chd_in_t  pending_words[$];
    chd_out_t expected_results[$];

    int send_wait      = 0;
    int words_accepted = 0;
    int recv_wait      = 0;
    int results_seen   = 0;
    int hold_off_left  = 0;
    logic hold_off_done = 1'b0;
    int mismatch_count = 0;

    // predictor state, set once at its declaration and not cleared by reset
    frame_phase_t frame_phase    = FR_IDLE;
    logic [63:0]  left_in_body   = '0;
    logic [4:0]   size_digits    = '0;
    logic         framed_chunked = 1'b0;
    logic         sticky_error   = 1'b0;

    http_body_chunked_deframer #(
        .MAX_SIZE_CHARS(SIZE_CHAR_WINDOW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: one deframed word for every accepted input word
    // ------------------------------------------------------------------
    function automatic chd_out_t deframe_word(chd_in_t w);
        chd_out_t   r;
        logic       bad;
        logic       is_hex;
        logic [3:0] nibble;
        r      = '0;
        bad    = 1'b0;
        is_hex = 1'b1;
        nibble = '0;
        // classify the byte as a hex digit of either case
        if (w.data_byte >= "0" && w.data_byte <= "9")
            nibble = 4'(w.data_byte - "0");
        else if (w.data_byte >= "a" && w.data_byte <= "f")
            nibble = 4'(w.data_byte - "a" + 8'd10);
        else if (w.data_byte >= "A" && w.data_byte <= "F")
            nibble = 4'(w.data_byte - "A" + 8'd10);
        else
            is_hex = 1'b0;

        // once the error is seen everything is ignored until reset
        if (!sticky_error)
        begin
            if (w.req_type == REQ_START)
            begin
                // a start abandons any body in progress without complaint
                framed_chunked = w.is_chunked;
                size_digits    = '0;
                left_in_body   = '0;
                if (w.is_chunked)
                    frame_phase = FR_SIZE_HEX;
                else if (w.content_length == '0)
                begin
                    // empty content-length body completes on the start itself
                    frame_phase = FR_COMPLETE;
                    r.body_done = 1'b1;
                end
                else
                begin
                    left_in_body = w.content_length;
                    frame_phase  = FR_COUNTED;
                end
            end
            else
            begin
                case (frame_phase)
                    FR_COUNTED, FR_CHUNK_DATA:
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = w.data_byte;
                        left_in_body--;
                        if (left_in_body == '0)
                        begin
                            if (frame_phase == FR_COUNTED)
                            begin
                                frame_phase = FR_COMPLETE;
                                r.body_done = 1'b1;
                            end
                            else
                                frame_phase = FR_CHUNK_CR;
                        end
                    end
                    FR_SIZE_HEX:
                    begin
                        if (is_hex)
                        begin
                            // leading zeros count toward the digit limit too
                            if (size_digits >= SIZE_DIGIT_LIMIT)
                                bad = 1'b1;
                            else
                            begin
                                left_in_body = {left_in_body[59:0], nibble};
                                size_digits++;
                            end
                        end
                        else if (w.data_byte == CHAR_CR && size_digits != '0)
                            frame_phase = FR_SIZE_LF;
                        else
                            bad = 1'b1;
                    end
                    FR_SIZE_LF:
                    begin
                        if (w.data_byte != CHAR_LF)
                            bad = 1'b1;
                        else
                        begin
                            size_digits = '0;
                            frame_phase = (left_in_body == '0) ? FR_LAST_CR : FR_CHUNK_DATA;
                        end
                    end
                    FR_CHUNK_CR:
                    begin
                        if (w.data_byte == CHAR_CR)
                            frame_phase = FR_CHUNK_LF;
                        else
                            bad = 1'b1;
                    end
                    FR_CHUNK_LF:
                    begin
                        if (w.data_byte == CHAR_LF)
                            frame_phase = FR_SIZE_HEX;
                        else
                            bad = 1'b1;
                    end
                    FR_LAST_CR:
                    begin
                        if (w.data_byte == CHAR_CR)
                            frame_phase = FR_LAST_LF;
                        else
                            bad = 1'b1;
                    end
                    FR_LAST_LF:
                    begin
                        if (w.data_byte == CHAR_LF)
                        begin
                            frame_phase = FR_COMPLETE;
                            r.body_done = 1'b1;
                        end
                        else
                            bad = 1'b1;
                    end
                    // idle or complete: no body open for this byte
                    default:
                        bad = 1'b1;
                endcase
            end
            if (bad)
            begin
                sticky_error = 1'b1;
                r            = '0;
            end
        end
        r.framing_error = sticky_error;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders, all appending to pending_words
    // ------------------------------------------------------------------
    task automatic push_start(logic chunked, logic [63:0] length);
        chd_in_t w;
        w.req_type       = REQ_START;
        w.is_chunked     = chunked;
        w.content_length = length;
        w.data_byte      = 8'($urandom);
        pending_words.push_back(w);
    endtask

    // unused framing fields carry noise so every bit gets toggled
    task automatic push_byte(logic [7:0] b);
        chd_in_t w;
        w.req_type       = REQ_BYTE;
        w.is_chunked     = 1'($urandom);
        w.content_length = {$urandom, $urandom};
        w.data_byte      = b;
        pending_words.push_back(w);
    endtask

    // size line: the given number of hex digits, random case, then crlf
    task automatic push_size_line(logic [63:0] size, int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--)
        begin
            nib = 4'(size >> (4 * i));
            if (nib < 4'd10)
                push_byte("0" + 8'(nib));
            else if ($urandom_range(0, 1) != 0)
                push_byte("A" + 8'(nib) - 8'd10);
            else
                push_byte("a" + 8'(nib) - 8'd10);
        end
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    // occasional leading zeros, up to a full-width size line
    function automatic int pad_zeros();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, SIZE_DIGIT_LIMIT - 2) : 0;
    endfunction

    // a whole chunked body: start, chunks, zero-size line, final crlf
    task automatic push_chunked_body(int chunks);
        int s;
        push_start(1'b1, {$urandom, $urandom});
        repeat (chunks)
        begin
            s = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(1, 31);
            push_size_line(64'(s), ((s > 15) ? 2 : 1) + pad_zeros());
            repeat (s)
                push_byte(8'($urandom));
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end
        push_size_line('0, 1 + pad_zeros());
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    task automatic push_counted_body(logic [63:0] length, int bytes_sent);
        push_start(1'b0, length);
        repeat (bytes_sent)
            push_byte(8'($urandom));
    endtask

    // idle draw per word, with stretches of back-to-back traffic
    function automatic int draw_wait(int count);
        return ((count / 160) % 3 == 0) ? 0 : $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued words, holds a stalled word, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid     <= 1'b0;
            item           <= '0;
            send_wait      <= 0;
            words_accepted <= 0;
        end
        else if (!(item_valid && item_stall))
        begin
            // word taken at this edge goes through the predictor
            if (item_valid)
            begin
                expected_results.push_back(deframe_word(item));
                words_accepted <= words_accepted + 1;
            end
            if (send_wait > 0)
            begin
                item_valid <= 1'b0;
                send_wait  <= send_wait - 1;
            end
            else if (pending_words.size() > 0)
            begin
                item_valid <= 1'b1;
                item       <= pending_words.pop_front();
                send_wait  <= draw_wait(words_accepted);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // one long receiver hold-off so the queue fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
            hold_off_done <= 1'b0;
        end
        else if (!hold_off_done && words_accepted >= HOLD_OFF_AFTER)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_left > 0)
            hold_off_left <= hold_off_left - 1;
    end

    task automatic note_mismatch(string what, chd_out_t want, chd_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t word %0d %s", $realtime, results_seen, what);
            $display("    expected pv=%b pb=%h done=%b err=%b",
                     want.payload_valid, want.payload_byte, want.body_done, want.framing_error);
            $display("    got      pv=%b pb=%h done=%b err=%b",
                     got.payload_valid, got.payload_byte, got.body_done, got.framing_error);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: checks every taken result word, stalls at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        chd_out_t want;
        string    bad_fields;
        int       next_wait;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_wait    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("no word expected", '0, result);
                else
                begin
                    want       = expected_results.pop_front();
                    bad_fields = "";
                    if (result.payload_valid !== want.payload_valid)
                        bad_fields = {bad_fields, " payload_valid"};
                    if (result.payload_byte !== want.payload_byte)
                        bad_fields = {bad_fields, " payload_byte"};
                    if (result.body_done !== want.body_done)
                        bad_fields = {bad_fields, " body_done"};
                    if (result.framing_error !== want.framing_error)
                        bad_fields = {bad_fields, " framing_error"};
                    if (bad_fields != "")
                        note_mismatch({"mismatch in", bad_fields}, want, result);
                end
                results_seen <= results_seen + 1;
                next_wait = draw_wait(results_seen);
            end
            else
                next_wait = (recv_wait > 0) ? recv_wait - 1 : 0;
            recv_wait    <= next_wait;
            result_stall <= (next_wait > 0) || (hold_off_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and verdict
    // ------------------------------------------------------------------
    initial
    begin : run_control
        int pick;
        int keep;
        int len;

        // directed: empty body, longest length cut short, one-byte body
        push_start(1'b0, '0);
        push_counted_body('1, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_counted_body(64'd1, 1);
        // chunked start restarted before any size digit
        push_start(1'b1, '1);
        // short chunked body: one byte chunk, then the zero-size line
        push_start(1'b1, '0);
        push_size_line(64'd1, 1);
        push_byte(8'hA5);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_size_line('0, 1);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);

        // random bodies; only well-formed prefixes, so no error yet
        while (pending_words.size() < BODY_WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_chunked_body($urandom_range(0, 3));
            else if (pick < 65)
            begin
                // short counted body sent in full, empty bodies included
                len = $urandom_range(0, 8);
                push_counted_body(64'(len), len);
            end
            else if (pick < 80)
            begin
                // chunked body cut off at a random point by the next start
                keep = pending_words.size() + $urandom_range(1, 30);
                push_chunked_body($urandom_range(1, 3));
                while (pending_words.size() > keep)
                    void'(pending_words.pop_back());
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_counted_body({$urandom, $urandom}, $urandom_range(1, 6));
                else
                begin
                    // full-width size line with a random value, abandoned
                    push_start(1'b1, {$urandom, $urandom});
                    push_size_line({$urandom, $urandom}, SIZE_DIGIT_LIMIT);
                    repeat ($urandom_range(0, 4))
                        push_byte(8'($urandom));
                end
            end
            else
                push_start(1'($urandom), {$urandom, $urandom});
        end

        // close with one framing fault, then check that the error sticks
        case ($urandom_range(0, 6))
            0:
            begin
                // byte after the body is complete
                push_counted_body(64'd1, 1);
                push_byte(8'($urandom));
            end
            1:
            begin
                // size line without digits
                push_start(1'b1, {$urandom, $urandom});
                push_byte(CHAR_CR);
            end
            2:
            begin
                // one digit beyond the size limit
                push_start(1'b1, {$urandom, $urandom});
                repeat (SIZE_DIGIT_LIMIT)
                    push_byte("0");
                push_byte("1");
            end
            3:
            begin
                // chunk extension is not accepted
                push_start(1'b1, {$urandom, $urandom});
                push_byte("2");
                push_byte(";");
            end
            4:
            begin
                // size line cr not followed by lf
                push_start(1'b1, {$urandom, $urandom});
                push_byte("3");
                push_byte(CHAR_CR);
                push_byte(CHAR_CR);
            end
            5:
            begin
                // chunk data not followed by cr
                push_start(1'b1, {$urandom, $urandom});
                push_size_line(64'd1, 1);
                push_byte(8'($urandom));
                push_byte("x");
            end
            default:
            begin
                // final line lacks its cr
                push_start(1'b1, {$urandom, $urandom});
                push_size_line('0, 1);
                push_byte(CHAR_LF);
            end
        endcase
        repeat (12)
        begin
            if ($urandom_range(0, 1) != 0)
                push_start(1'($urandom), 64'($urandom_range(0, 3)));
            else
                push_byte(8'($urandom));
        end

        rst_n = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything offered, taken and answered, sampled away from the edge
        do
            @(negedge clk);
        while (pending_words.size() != 0 || item_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (expected_results.size() != 0)
            $display("%0d expected words never arrived", expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("http_body_chunked_deframer verification clean");
        else
            $display("http_body_chunked_deframer verification failed");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("http_body_chunked_deframer verification failed");
        $finish;
    end

endmodule
